>>> hdl/ftrr_pkg.sv
package ftrr_pkg;

   localparam int TimeWidth = 32;
   localparam int WinWidth  = 31;
   localparam int CurWidth  = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 32;

   localparam logic [WinWidth-1:0] CHARGER_WINDOW_RESET   = 31'd3600000;
   localparam logic [WinWidth-1:0] MONITOR_WINDOW_RESET   = 31'd10000;
   localparam logic [WinWidth-1:0] HEARTBEAT_WINDOW_RESET = 31'd0;

   typedef enum logic [1:0] {
      MODE_UPDATE    = 2'd0,
      MODE_HEARTBEAT = 2'd1,
      MODE_ACK       = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      TARGET_CHARGER    = 2'd0,
      TARGET_MONITOR    = 2'd1,
      TARGET_CONTROLLER = 2'd2
   } ack_target_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_CHARGER_WINDOW   = 2'd0,
      CSR_MONITOR_WINDOW   = 2'd1,
      CSR_HEARTBEAT_WINDOW = 2'd2
   } csr_index_type;

   typedef struct packed {
      mode_type                    mode;
      logic [TimeWidth-1:0]        now_ms;
      logic                        charge_sample_ok;
      logic signed [CurWidth-1:0]  charge_current_ma;
      logic                        monitor_answered;
      ack_target_type              ack_target;
   } req_type;

   typedef struct packed {
      logic charger_rst;
      logic monitor_reset;
      logic controller_reset;
   } rsp_type;

   // per-transaction control for one fault-episode channel
   typedef struct packed {
      logic update;
      logic ack;
      logic fault;
   } chan_ctl_type;

endpackage

>>> hdl/ftrr_chan.sv
module ftrr_chan (
   input  logic                             clock,
   input  logic                             reset,
   input  ftrr_pkg::chan_ctl_type           ctl,
   input  logic [ftrr_pkg::TimeWidth-1:0]   now_ms,
   input  logic [ftrr_pkg::WinWidth-1:0]    win_len,
   output logic                             request
);
   import ftrr_pkg::*;

   logic                 active_ff, active_in;
   logic                 latched_ff, latched_in;
   logic [TimeWidth-1:0] start_ff, start_in;
   logic [TimeWidth-1:0] elapsed;
   logic                 past_window;

   // wrap-safe elapsed time
   assign elapsed     = now_ms - start_ff;
   assign past_window = elapsed > {1'b0, win_len};

   always_comb begin
      active_in  = active_ff;
      latched_in = latched_ff;
      start_in   = start_ff;
      request    = 1'b0;
      if (ctl.update) begin
         if ((win_len == '0) || !ctl.fault) begin
            active_in  = 1'b0;
            latched_in = 1'b0;
            start_in   = '0;
         end else if (!active_ff) begin
            active_in = 1'b1;
            start_in  = now_ms;
         end else if (latched_ff) begin
            request = 1'b1;
         end else if (past_window) begin
            latched_in = 1'b1;
            request    = 1'b1;
         end
      end else if (ctl.ack) begin
         // restart the window of an open episode
         latched_in = 1'b0;
         start_in   = active_ff ? now_ms : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         latched_ff <= 1'b0;
         start_ff   <= '0;
      end else begin
         active_ff  <= active_in;
         latched_ff <= latched_in;
         start_ff   <= start_in;
      end
   end

endmodule

>>> hdl/fault_timeout_reset_requester.sv
// Reset requester for a power subsystem: charger, battery monitor and
// power-controller heartbeat channels.
//
// Channels:
//   req_*  transaction in (valid/ready): mode, millisecond tick, samples,
//          acknowledge target.
//   rsp_*  transaction out (valid/ready): the three reset request levels.
//          Only update transactions give a response.
//   csr_*  window register writes (valid/ready, always ready); write only
//          while no transaction is in flight.
// Timing: a request transaction is registered at the input and evaluated
// against the channel state while it is held there; an update's response
// loads into the output register as the transaction advances, and rsp_valid
// is driven straight from that register.
// Throughput: one transaction per cycle while the output is not stalled; the
// state update is one subtract and compare per channel between the registers.
// Reset: all channel state clears, windows take their default values, no
// response is pending. When the receiver stalls, the response holds in the
// output register; the input register holds one more transaction, and
// heartbeat and acknowledge transactions still pass behind a stalled one.
module fault_timeout_reset_requester (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ftrr_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ftrr_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ftrr_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [ftrr_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import ftrr_pkg::*;

   // window registers
   logic [WinWidth-1:0]  chg_window_ff, mon_window_ff, hb_window_ff;

   // input stage
   logic                 in_valid_ff, in_valid_in;
   req_type              in_data_ff, in_data_in;

   // heartbeat channel state
   logic [TimeWidth-1:0] beat_anchor_ff, beat_anchor_in;
   logic                 beat_latched_ff, beat_latched_in;

   // output stage
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 is_update, advance;
   logic                 fire_update, fire_ack;
   logic                 chg_fault, hb_past;
   logic [TimeWidth-1:0] hb_elapsed;
   logic                 chg_request, mon_request;
   chan_ctl_type         chg_ctl, mon_ctl;

   // config writes are taken at once
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         chg_window_ff <= CHARGER_WINDOW_RESET;
         mon_window_ff <= MONITOR_WINDOW_RESET;
         hb_window_ff  <= HEARTBEAT_WINDOW_RESET;
      end else if (csr_valid) begin
         // keep the low 31 bits; drop writes to unknown indexes
         case (csr_index)
            CSR_CHARGER_WINDOW:   chg_window_ff <= csr_wdata[WinWidth-1:0];
            CSR_MONITOR_WINDOW:   mon_window_ff <= csr_wdata[WinWidth-1:0];
            CSR_HEARTBEAT_WINDOW: hb_window_ff  <= csr_wdata[WinWidth-1:0];
            default: ;
         endcase
      end
   end

   // Advance the held transaction unless it needs the output register and
   // that register still holds an untaken response.
   assign is_update   = in_data_ff.mode == MODE_UPDATE;
   assign advance     = in_valid_ff && (!is_update || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || advance;
   assign fire_update = advance && is_update;
   assign fire_ack    = advance && (in_data_ff.mode == MODE_ACK);

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_data_in  = req_data;
      end
   end

   // charger fault: sample read and current at or below zero
   assign chg_fault = in_data_ff.charge_sample_ok &&
                      ((in_data_ff.charge_current_ma == '0) ||
                       in_data_ff.charge_current_ma[CurWidth-1]);

   assign chg_ctl.update = fire_update;
   assign chg_ctl.ack    = fire_ack && (in_data_ff.ack_target == TARGET_CHARGER);
   assign chg_ctl.fault  = chg_fault;

   assign mon_ctl.update = fire_update;
   assign mon_ctl.ack    = fire_ack && (in_data_ff.ack_target == TARGET_MONITOR);
   assign mon_ctl.fault  = !in_data_ff.monitor_answered;

   ftrr_chan u_chg_chan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (chg_ctl),
      .now_ms    (in_data_ff.now_ms),
      .win_len   (chg_window_ff),
      .request   (chg_request)
   );

   ftrr_chan u_mon_chan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (mon_ctl),
      .now_ms    (in_data_ff.now_ms),
      .win_len   (mon_window_ff),
      .request   (mon_request)
   );

   // heartbeat: request while the window is nonzero and the time since the anchor exceeds it
   assign hb_elapsed = in_data_ff.now_ms - beat_anchor_ff;
   assign hb_past    = (hb_window_ff != '0) && (hb_elapsed > {1'b0, hb_window_ff});

   always_comb begin
      beat_anchor_in  = beat_anchor_ff;
      beat_latched_in = beat_latched_ff;
      if (fire_update) begin
         beat_latched_in = hb_past;
      end else if (advance && (in_data_ff.mode == MODE_HEARTBEAT)) begin
         beat_anchor_in = in_data_ff.now_ms;
      end else if (fire_ack && (in_data_ff.ack_target == TARGET_CONTROLLER)) begin
         // rearm the heartbeat only after a reset was actually requested
         if (beat_latched_ff) begin
            beat_anchor_in = in_data_ff.now_ms;
         end
         beat_latched_in = 1'b0;
      end
   end

   // output register: load on an update, drop once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (fire_update) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.charger_rst      = chg_request;
         rsp_data_in.monitor_reset    = mon_request;
         rsp_data_in.controller_reset = hb_past;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         beat_anchor_ff  <= '0;
         beat_latched_ff <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         beat_anchor_ff  <= beat_anchor_in;
         beat_latched_ff <= beat_latched_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hdl/ftrr_checker.sv
module ftrr_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input ftrr_pkg::req_type                    req_data,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input ftrr_pkg::rsp_type                    rsp_data,
   input logic                                 csr_valid,
   input logic                                 csr_ready
);
   import ftrr_pkg::*;

   // no response survives reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response pending after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // a new response comes from an update that passed the input register unstalled
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready &&
                                 req_data.mode == MODE_UPDATE, 2))
      else $error("response without an update transaction");

   // a taken response always frees the input side
   a_drain_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |-> req_ready)
      else $error("input stalled while the response drains");

   // the register port never stalls
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind fault_timeout_reset_requester ftrr_checker u_ftrr_checker (.*);

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import ftrr_pkg::*;

   // Codes that the package leaves unnamed but the block must tolerate.
   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam logic [1:0] TARGET_NONE    = 2'd3;
   localparam logic [1:0] CSR_NOT_MAPPED = 2'd3;

   localparam int IdleMax        = 12;
   localparam int LongHoldCycles = 80;
   localparam int DrainCycles    = 8;
   localparam int StuckLimit     = 2000;

   // Tracks the fault episodes and heartbeat anchor of the block and keeps
   // the reset levels that each update transaction must produce.
   class reset_request_tracker;
      typedef struct packed {
         logic                 active;
         logic                 latched;
         logic [TimeWidth-1:0] start;
      } episode_type;

      logic [WinWidth-1:0]  chg_win;
      logic [WinWidth-1:0]  mon_win;
      logic [WinWidth-1:0]  beat_win;
      episode_type          chg;
      episode_type          mon;
      logic [TimeWidth-1:0] beat_anchor;
      logic                 beat_latched;
      rsp_type              levels_due[$];
      int                   errors;

      function new();
         chg_win      = CHARGER_WINDOW_RESET;
         mon_win      = MONITOR_WINDOW_RESET;
         beat_win     = HEARTBEAT_WINDOW_RESET;
         chg          = '0;
         mon          = '0;
         beat_anchor  = '0;
         beat_latched = 1'b0;
         errors       = 0;
      endfunction

      function void write_window(logic [1:0] idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_CHARGER_WINDOW:   chg_win  = data[WinWidth-1:0];
            CSR_MONITOR_WINDOW:   mon_win  = data[WinWidth-1:0];
            CSR_HEARTBEAT_WINDOW: beat_win = data[WinWidth-1:0];
            default: ;
         endcase
      endfunction

      function logic advance_episode(inout episode_type ep, input logic [TimeWidth-1:0] now,
                                     input logic [WinWidth-1:0] win, input logic fault);
         logic [TimeWidth-1:0] elapsed;
         elapsed = now - ep.start;
         if (win == '0 || !fault) begin
            ep = '0;
            return 1'b0;
         end
         if (!ep.active) begin
            ep.active = 1'b1;
            ep.start  = now;
            return 1'b0;
         end
         if (ep.latched)
            return 1'b1;
         if (elapsed > {1'b0, win}) begin
            ep.latched = 1'b1;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void restart_episode(inout episode_type ep, input logic [TimeWidth-1:0] now);
         ep.latched = 1'b0;
         ep.start   = ep.active ? now : '0;
      endfunction

      function void note_request(req_type r);
         rsp_type              lv;
         logic                 chg_fault;
         logic [TimeWidth-1:0] since_beat;
         case (r.mode)
            MODE_UPDATE: begin
               chg_fault  = r.charge_sample_ok && ($signed(r.charge_current_ma) <= 0);
               since_beat = r.now_ms - beat_anchor;
               lv.charger_rst = advance_episode(chg, r.now_ms, chg_win, chg_fault);
               lv.monitor_reset = advance_episode(mon, r.now_ms, mon_win, !r.monitor_answered);
               beat_latched = (beat_win != '0) && (since_beat > {1'b0, beat_win});
               lv.controller_reset = beat_latched;
               levels_due.push_back(lv);
            end
            MODE_HEARTBEAT: beat_anchor = r.now_ms;
            MODE_ACK: begin
               case (r.ack_target)
                  TARGET_CHARGER: restart_episode(chg, r.now_ms);
                  TARGET_MONITOR: restart_episode(mon, r.now_ms);
                  TARGET_CONTROLLER: begin
                     if (beat_latched)
                        beat_anchor = r.now_ms;
                     beat_latched = 1'b0;
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      endfunction

      function void check_levels(rsp_type got);
         rsp_type want;
         if (levels_due.size() == 0) begin
            $error("response with no update pending: %b", got);
            errors++;
            return;
         end
         want = levels_due.pop_front();
         if (got.charger_rst !== want.charger_rst) begin
            $error("charger_rst expected %b actual %b", want.charger_rst, got.charger_rst);
            errors++;
         end
         if (got.monitor_reset !== want.monitor_reset) begin
            $error("monitor_reset expected %b actual %b", want.monitor_reset, got.monitor_reset);
            errors++;
         end
         if (got.controller_reset !== want.controller_reset) begin
            $error("controller_reset expected %b actual %b", want.controller_reset,
                   got.controller_reset);
            errors++;
         end
      endfunction

      function int pending();
         return levels_due.size();
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   req_type                  req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   rsp_type                  rsp_data;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   reset_request_tracker tracker = new();

   bit                   idle_enable    = 1'b1;  // random gaps on both channels
   bit                   rsp_hold_asked = 1'b0;  // ask the sink for one long stall
   logic [TimeWidth-1:0] tick_ms;                // running millisecond timeline
   int                   stuck_cycles   = 0;

   fault_timeout_reset_requester i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe both channels at the edge: note every accepted request
   // transaction, check every accepted response transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_request(req_data);
         if (rsp_valid && rsp_ready)
            tracker.check_levels(rsp_data);
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Response sink: random stall bursts, plus one long hold on request so
   // that the block backs up into its input.
   initial begin : rsp_sink
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_asked) begin
            rsp_hold_asked = 1'b0;
            stall_left     = LongHoldCycles;
         end else if (stall_left == 0 && idle_enable && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, IdleMax);
         end
         if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one request transaction and hold it until accepted. Valid stays
   // high on return, so back-to-back transactions show no gap.
   task automatic send_request(input req_type r);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, IdleMax)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold a register write until accepted; the caller drops csr_valid.
   task automatic write_csr(input logic [1:0] idx, input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_window(idx, data);
   endtask

   // Drop valid, wait for every pending response, then let heartbeat and
   // acknowledge transactions still in flight pass the pipeline.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Program all three windows on an idle block; bit 31 of the data is
   // random and must be dropped, and a write to the unmapped index is
   // mixed in now and then.
   task automatic configure(input logic [WinWidth-1:0] chg_w, mon_w, beat_w);
      wait_drained();
      write_csr(CSR_CHARGER_WINDOW, {1'($urandom), chg_w});
      write_csr(CSR_MONITOR_WINDOW, {1'($urandom), mon_w});
      write_csr(CSR_HEARTBEAT_WINDOW, {1'($urandom), beat_w});
      if ($urandom_range(0, 1) == 0)
         write_csr(CSR_NOT_MAPPED, $urandom);
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_request(input logic [1:0] mode, input logic [31:0] now,
                                            input logic ok, input logic signed [15:0] cur,
                                            input logic answered, input logic [1:0] target);
      req_type r;
      r.mode              = mode_type'(mode);
      r.now_ms            = now;
      r.charge_sample_ok  = ok;
      r.charge_current_ma = cur;
      r.monitor_answered  = answered;
      r.ack_target        = ack_target_type'(target);
      return r;
   endfunction

   // Mostly a monotonic timeline with faults held long enough to latch;
   // a few transactions carry a random tick or an unused mode.
   function automatic req_type random_request(input int unsigned max_step,
                                              input bit wide_jumps);
      req_type     r;
      int unsigned pick;
      if (wide_jumps && $urandom_range(0, 1) == 0)
         tick_ms += $urandom;
      else
         tick_ms += $urandom_range(0, max_step);
      pick = $urandom_range(0, 19);
      if (pick < 12)
         r.mode = MODE_UPDATE;
      else if (pick < 15)
         r.mode = MODE_HEARTBEAT;
      else if (pick < 19)
         r.mode = MODE_ACK;
      else
         r.mode = mode_type'(MODE_UNUSED);
      r.now_ms           = ($urandom_range(0, 19) == 0) ? $urandom : tick_ms;
      r.charge_sample_ok = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 5))
         0:       r.charge_current_ma = 16'sd0;
         1:       r.charge_current_ma = 16'sh8000;
         2:       r.charge_current_ma = 16'sh7FFF;
         3:       r.charge_current_ma = -16'sd1;
         4:       r.charge_current_ma = 16'($urandom_range(1, 32767));
         default: r.charge_current_ma = 16'($urandom);
      endcase
      r.monitor_answered = ($urandom_range(0, 4) == 0);
      r.ack_target       = ack_target_type'($urandom_range(0, 3));
      return r;
   endfunction

   task automatic send_random(input int count, input int unsigned max_step,
                              input bit wide_jumps);
      for (int i = 0; i < count; i++)
         send_request(random_request(max_step, wide_jumps));
   endtask

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: default windows. Open both episodes, let monitor then
      // charger latch, acknowledge each, clear them, and walk every mode.
      send_request(make_request(MODE_UPDATE, 32'd0, 1'b1, 16'sd0, 1'b0, TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'd10001, 1'b1, 16'sh8000, 1'b0,
                                TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'd3600001, 1'b1, -16'sd1, 1'b0,
                                TARGET_MONITOR));
      send_request(make_request(MODE_ACK, 32'd3600002, 1'b1, 16'sd0, 1'b0, TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'd3600003, 1'b1, 16'sh7FFF, 1'b0,
                                TARGET_CHARGER));
      send_request(make_request(MODE_ACK, 32'd3600004, 1'b0, 16'sd0, 1'b0, TARGET_MONITOR));
      send_request(make_request(MODE_UPDATE, 32'd3600005, 1'b1, 16'sd1, 1'b1, TARGET_NONE));
      send_request(make_request(MODE_HEARTBEAT, 32'd5, 1'b0, 16'sd0, 1'b1, TARGET_CHARGER));
      send_request(make_request(MODE_ACK, 32'd6, 1'b0, 16'sd0, 1'b1, TARGET_CONTROLLER));
      send_request(make_request(MODE_ACK, 32'd7, 1'b1, 16'sd0, 1'b0, TARGET_NONE));
      send_request(make_request(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1, 16'sh8000, 1'b0,
                                TARGET_NONE));
      send_request(make_request(MODE_UPDATE, 32'd8, 1'b0, 16'sd0, 1'b1, TARGET_CHARGER));

      // Arm the heartbeat, push the episode windows to their maximum through
      // out-of-range data, and poke the unmapped index.
      wait_drained();
      write_csr(CSR_HEARTBEAT_WINDOW, 32'd100);
      write_csr(CSR_CHARGER_WINDOW, 32'hFFFF_FFFF);
      write_csr(CSR_MONITOR_WINDOW, 32'hFFFF_FFFF);
      write_csr(CSR_NOT_MAPPED, 32'h0000_0001);
      csr_valid <= 1'b0;

      // Heartbeat just before the tick wraps, time out across the wrap,
      // acknowledge, then an elapsed time of 2^31-1 and of 2^31.
      send_request(make_request(MODE_HEARTBEAT, 32'hFFFF_FFF0, 1'b0, 16'sd0, 1'b1,
                                TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'h0000_0050, 1'b0, 16'sd0, 1'b1,
                                TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'h0000_0065, 1'b0, 16'sd0, 1'b1,
                                TARGET_CHARGER));
      send_request(make_request(MODE_ACK, 32'h0000_0070, 1'b0, 16'sd0, 1'b1,
                                TARGET_CONTROLLER));
      send_request(make_request(MODE_UPDATE, 32'h0000_0070, 1'b0, 16'sd0, 1'b1,
                                TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'h0000_0100, 1'b1, 16'sd0, 1'b0,
                                TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'h8000_00FF, 1'b1, 16'sh8000, 1'b0,
                                TARGET_CHARGER));
      send_request(make_request(MODE_UPDATE, 32'h8000_0100, 1'b1, -16'sd1, 1'b0,
                                TARGET_CHARGER));
      send_request(make_request(MODE_HEARTBEAT, 32'h8000_0100, 1'b1, 16'sd0, 1'b0,
                                TARGET_CHARGER));

      // Random part. Start near the top of the tick range so the timeline
      // wraps early.
      tick_ms = 32'hFFFF_F000 + $urandom_range(0, 32'h0FFF);

      configure(31'd50, 31'd30, 31'd70);
      send_random(90, 25, 1'b0);
      // Hold off the sink for a long stretch while requests keep coming.
      rsp_hold_asked = 1'b1;
      send_random(90, 25, 1'b0);

      // All channels disarmed.
      configure(31'd0, 31'd0, 31'd0);
      send_random(60, 20, 1'b0);

      // Smallest nonzero windows.
      configure(31'd1, 31'd1, 31'd1);
      send_random(120, 3, 1'b0);

      // Largest windows with random jumps anywhere in the tick range.
      configure(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_random(120, 3, 1'b1);

      // Mixed: monitor disarmed. Pause midway until every response is back.
      configure(31'd200, 31'd0, 31'd40);
      send_random(75, 60, 1'b0);
      wait_drained();
      send_random(75, 60, 1'b0);

      // Last stretch at full rate on both sides.
      configure(31'd25, 31'd25, 31'd25);
      idle_enable = 1'b0;
      send_random(200, 15, 1'b0);

      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (tracker.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
hdl/ftrr_pkg.sv
hdl/ftrr_chan.sv
hdl/fault_timeout_reset_requester.sv
hdl/ftrr_checker.sv
dv/tb.sv
